// ----- design/windowed_min_clock_offset_unit_macros.svh -----
// Assertion macros shared by the checker of the clock offset unit.
`ifndef WINDOWED_MIN_CLOCK_OFFSET_UNIT_MACROS_SVH
`define WINDOWED_MIN_CLOCK_OFFSET_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WMCO_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wmco assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define WMCO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wmco assertion failed");

`endif

// ----- design/wmco_pkg.sv -----
// Package: window size, derived widths and controller/datapath interface types.
package wmco_pkg;

  localparam int WINDOW = 512;
  localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int TS_W   = 63;
  localparam int OFS_W  = 64;

  typedef struct packed {
    logic capture;
    logic write;
    logic read;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic absent;
    logic scan_last;
    logic out_busy;
  } status_t;

endpackage

// ----- design/wmco_datapath.sv -----
// Datapath: input registers, offset ring memory, minimum scan and output register.
module wmco_datapath (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  wmco_pkg::cmd_t                  cmd_i,
  output wmco_pkg::status_t               status_o,
  input  logic [wmco_pkg::TS_W-1:0]       device_time_ns_i,
  input  logic [wmco_pkg::TS_W-1:0]       arrival_time_ns_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [wmco_pkg::OFS_W-1:0] host_time_ns_o,
  output logic signed [wmco_pkg::OFS_W-1:0] clock_offset_ns_o,
  output logic                            timestamp_absent_o
);

  logic [wmco_pkg::TS_W-1:0]         dev_q, arr_q;
  logic [wmco_pkg::CNT_W-1:0]        fill_q;
  logic [wmco_pkg::IDX_W-1:0]        slot_q;
  logic [wmco_pkg::IDX_W-1:0]        scan_idx_q;
  logic                              rd_valid_q, rd_first_q;
  logic signed [wmco_pkg::OFS_W-1:0] rd_data_q;
  logic signed [wmco_pkg::OFS_W-1:0] min_q;
  logic signed [wmco_pkg::OFS_W-1:0] ring [wmco_pkg::WINDOW];

  logic                              out_valid_q;
  logic signed [wmco_pkg::OFS_W-1:0] host_q, ofs_q;
  logic                              absent_q;

  logic                              absent;
  logic                              filling;
  logic [wmco_pkg::IDX_W-1:0]        wr_addr;
  logic signed [wmco_pkg::OFS_W-1:0] diff;
  logic signed [wmco_pkg::OFS_W:0]   sum;
  logic signed [wmco_pkg::OFS_W-1:0] sat_sum, host;

  assign absent  = (dev_q == '0);
  assign filling = (fill_q < wmco_pkg::CNT_W'(wmco_pkg::WINDOW));
  assign wr_addr = filling ? fill_q[wmco_pkg::IDX_W-1:0] : slot_q;
  assign diff    = $signed({1'b0, arr_q}) - $signed({1'b0, dev_q});

  // dev_q is non-negative, so only positive overflow can occur
  assign sum     = $signed({2'b00, dev_q}) + $signed({min_q[wmco_pkg::OFS_W-1], min_q});
  assign sat_sum = (!sum[wmco_pkg::OFS_W] && sum[wmco_pkg::OFS_W-1])
                 ? {1'b0, {(wmco_pkg::OFS_W-1){1'b1}}}
                 : sum[wmco_pkg::OFS_W-1:0];
  assign host    = (sat_sum > $signed({1'b0, arr_q})) ? $signed({1'b0, arr_q}) : sat_sum;

  assign status_o.absent    = absent;
  assign status_o.scan_last = (wmco_pkg::CNT_W'(scan_idx_q) == fill_q - wmco_pkg::CNT_W'(1));
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      ring[wr_addr] <= diff;
    end
    if (cmd_i.read) begin
      rd_data_q <= ring[scan_idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dev_q <= device_time_ns_i;
      arr_q <= arrival_time_ns_i;
    end
    if (cmd_i.load_out) begin
      host_q   <= absent ? $signed({1'b0, arr_q}) : host;
      ofs_q    <= min_q;
      absent_q <= absent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      slot_q      <= '0;
      scan_idx_q  <= '0;
      rd_valid_q  <= 1'b0;
      rd_first_q  <= 1'b0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.write) begin
        scan_idx_q <= '0;
        if (filling) begin
          fill_q <= fill_q + wmco_pkg::CNT_W'(1);
        end else if (slot_q == wmco_pkg::IDX_W'(wmco_pkg::WINDOW - 1)) begin
          slot_q <= '0;
        end else begin
          slot_q <= slot_q + wmco_pkg::IDX_W'(1);
        end
      end else if (cmd_i.read) begin
        scan_idx_q <= scan_idx_q + wmco_pkg::IDX_W'(1);
      end
      rd_valid_q <= cmd_i.read;
      rd_first_q <= cmd_i.read && (scan_idx_q == '0);
      if (rd_valid_q && (rd_first_q || rd_data_q < min_q)) begin
        min_q <= rd_data_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign host_time_ns_o     = host_q;
  assign clock_offset_ns_o  = ofs_q;
  assign timestamp_absent_o = absent_q;

endmodule

// ----- design/wmco_ctrl.sv -----
// Controller: sequences capture, ring write, window scan and result load.
module wmco_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wmco_pkg::status_t status_i,
  output wmco_pkg::cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.capture  = (state_q == ST_IDLE) && in_valid_i;
    cmd_o.write    = (state_q == ST_WRITE) && !status_i.absent;
    cmd_o.read     = (state_q == ST_SCAN);
    cmd_o.load_out = (state_q == ST_DONE) && !status_i.out_busy;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_WRITE;
        end
        ST_WRITE: begin
          state_q <= status_i.absent ? ST_DONE : ST_SCAN;
        end
        ST_SCAN: begin
          if (status_i.scan_last) state_q <= ST_DRAIN;
        end
        ST_DRAIN: begin
          state_q <= ST_DONE;
        end
        ST_DONE: begin
          if (!status_i.out_busy) state_q <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/windowed_min_clock_offset_unit.sv -----
// Top level of the windowed minimum clock offset unit.
// One transaction at a time: a timestamped item's processing time grows with the
// window fill, set by the scan that reads one ring entry per cycle through the
// single memory read port; an item with zero device time skips the scan.
// The result register frees the input side, so the next item is accepted as
// soon as a result is loaded, even while that result still waits to be taken.
module windowed_min_clock_offset_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [wmco_pkg::TS_W-1:0]         device_time_ns_i,
  input  logic [wmco_pkg::TS_W-1:0]         arrival_time_ns_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [wmco_pkg::OFS_W-1:0] host_time_ns_o,
  output logic signed [wmco_pkg::OFS_W-1:0] clock_offset_ns_o,
  output logic                              timestamp_absent_o
);

  wmco_pkg::cmd_t    cmd;
  wmco_pkg::status_t status;

  wmco_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wmco_datapath u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .device_time_ns_i   (device_time_ns_i),
    .arrival_time_ns_i  (arrival_time_ns_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .host_time_ns_o     (host_time_ns_o),
    .clock_offset_ns_o  (clock_offset_ns_o),
    .timestamp_absent_o (timestamp_absent_o)
  );

endmodule

// ----- design/wmco_checker.sv -----
// Port-level checker for the clock offset unit, bound to the top level.
`include "windowed_min_clock_offset_unit_macros.svh"

module wmco_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic [wmco_pkg::TS_W-1:0]         device_time_ns_i,
  input logic [wmco_pkg::TS_W-1:0]         arrival_time_ns_i,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic signed [wmco_pkg::OFS_W-1:0] host_time_ns_o,
  input logic signed [wmco_pkg::OFS_W-1:0] clock_offset_ns_o,
  input logic                              timestamp_absent_o
);

  // stalled result holds
  `WMCO_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i,
    out_valid_o && $stable(host_time_ns_o) && $stable(clock_offset_ns_o) && $stable(timestamp_absent_o))

  // one transaction in flight: ready drops after an accept
  `WMCO_ASSERT_NEXT(a_one_inflight, in_valid_i && in_ready_o, !in_ready_o)

  // pass-through arrival time is never negative
  `WMCO_ASSERT_IMPL(a_absent_nonneg, out_valid_o && timestamp_absent_o,
    !host_time_ns_o[wmco_pkg::OFS_W-1])

endmodule

bind windowed_min_clock_offset_unit wmco_checker u_wmco_checker (.*);

// ----- tb/windowed_min_clock_offset_unit_test.sv -----
// Self-checking testbench for the windowed minimum clock offset unit.
module windowed_min_clock_offset_unit_test;

  localparam int WATCHDOG_LIMIT = 16000;
  localparam int HOLD_AT        = 40;
  localparam int HOLD_CYCLES    = 1500;
  localparam int TAIL_CYCLES    = 600;
  localparam int RANDOM_ITEMS   = 1140;
  localparam logic signed [wmco_pkg::OFS_W-1:0] OFS_MAX = {1'b0, {(wmco_pkg::OFS_W-1){1'b1}}};
  localparam logic [wmco_pkg::TS_W-1:0]         TS_MAX  = '1;

  typedef struct {
    logic [wmco_pkg::TS_W-1:0] device_ns;
    logic [wmco_pkg::TS_W-1:0] arrival_ns;
    bit                        drain_first;
  } stim_t;

  typedef struct {
    logic signed [wmco_pkg::OFS_W-1:0] host_ns;
    logic signed [wmco_pkg::OFS_W-1:0] offset_ns;
    logic                              absent;
  } host_time_t;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_ready;
  logic [wmco_pkg::TS_W-1:0]         device_time = '0;
  logic [wmco_pkg::TS_W-1:0]         arrival_time = '0;
  logic                              out_valid;
  logic                              out_ready = 1'b0;
  logic signed [wmco_pkg::OFS_W-1:0] host_time;
  logic signed [wmco_pkg::OFS_W-1:0] clock_offset;
  logic                              timestamp_absent;

  windowed_min_clock_offset_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid),
    .in_ready_o         (in_ready),
    .device_time_ns_i   (device_time),
    .arrival_time_ns_i  (arrival_time),
    .out_valid_o        (out_valid),
    .out_ready_i        (out_ready),
    .host_time_ns_o     (host_time),
    .clock_offset_ns_o  (clock_offset),
    .timestamp_absent_o (timestamp_absent)
  );

  always #4 clk_i = ~clk_i;

  stim_t      pending_items[$];
  host_time_t host_time_predictions[$];

  logic signed [wmco_pkg::OFS_W-1:0] offset_window[wmco_pkg::WINDOW];
  int                                window_fill = 0;
  int                                overwrite_slot = 0;
  logic signed [wmco_pkg::OFS_W-1:0] min_offset = '0;

  int n_sent = 0;
  int n_results = 0;
  int n_absent = 0;
  int n_overwrites = 0;
  int n_failures = 0;
  int idle_cycles = 0;

  bit    offering = 1'b0;
  int    send_gap = 0;
  int    take_gap = 0;
  int    hold_left = 0;
  bit    take;
  stim_t next_item;

  function automatic int draw_gap(int n);
    if ((n / 64) % 4 == 0) return 0;
    return $urandom_range(0, 8);
  endfunction

  task automatic track_clock_offset(input logic [wmco_pkg::TS_W-1:0] dev,
                                    input logic [wmco_pkg::TS_W-1:0] arr);
    logic signed [wmco_pkg::OFS_W-1:0] dev_s;
    logic signed [wmco_pkg::OFS_W-1:0] arr_s;
    logic signed [wmco_pkg::OFS_W-1:0] host;
    host_time_t                        res;
    dev_s = {1'b0, dev};
    arr_s = {1'b0, arr};
    if (dev == '0) begin
      res.host_ns   = arr_s;
      res.offset_ns = min_offset;
      res.absent    = 1'b1;
      n_absent++;
    end else begin
      if (window_fill < wmco_pkg::WINDOW) begin
        offset_window[window_fill] = arr_s - dev_s;
        window_fill++;
      end else begin
        offset_window[overwrite_slot] = arr_s - dev_s;
        overwrite_slot = (overwrite_slot + 1) % wmco_pkg::WINDOW;
        n_overwrites++;
      end
      min_offset = offset_window[0];
      for (int i = 1; i < window_fill; i++)
        if (offset_window[i] < min_offset) min_offset = offset_window[i];
      if (min_offset > 0 && dev_s > OFS_MAX - min_offset) host = OFS_MAX;
      else host = dev_s + min_offset;
      if (host > arr_s) host = arr_s;
      res.host_ns   = host;
      res.offset_ns = min_offset;
      res.absent    = 1'b0;
    end
    host_time_predictions.push_back(res);
  endtask

  // Driver: one item in flight on the input side at a time.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid     <= 1'b0;
      device_time  <= '0;
      arrival_time <= '0;
      offering = 1'b0;
      send_gap = 0;
    end else begin
      if (offering && in_ready) begin
        track_clock_offset(device_time, arrival_time);
        n_sent++;
        offering = 1'b0;
        send_gap = draw_gap(n_sent);
      end
      if (!offering) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].drain_first && host_time_predictions.size() > 0)) begin
          next_item = pending_items.pop_front();
          device_time  <= next_item.device_ns;
          arrival_time <= next_item.arrival_ns;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // Monitor: checks each result transaction against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    host_time_t want;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      take_gap = 0;
      hold_left = 0;
    end else begin
      if (out_ready && out_valid) begin
        n_results++;
        if (host_time_predictions.size() == 0) begin
          $error("result with no prediction pending: host_time_ns %0d", host_time);
          n_failures++;
        end else begin
          want = host_time_predictions.pop_front();
          if (host_time !== want.host_ns) begin
            $error("host_time_ns: expected %0d, got %0d", want.host_ns, host_time);
            n_failures++;
          end
          if (clock_offset !== want.offset_ns) begin
            $error("clock_offset_ns: expected %0d, got %0d", want.offset_ns, clock_offset);
            n_failures++;
          end
          if (timestamp_absent !== want.absent) begin
            $error("timestamp_absent: expected %0b, got %0b", want.absent, timestamp_absent);
            n_failures++;
          end
        end
        take_gap = draw_gap(n_results);
        if (n_results == HOLD_AT) hold_left = HOLD_CYCLES;
      end
      take = 1'b0;
      if (hold_left > 0) hold_left--;
      else if (take_gap > 0) take_gap--;
      else take = 1'b1;
      out_ready <= take;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without a transaction", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic signed [wmco_pkg::OFS_W-1:0] arr_clock;
    logic signed [wmco_pkg::OFS_W-1:0] skew;
    logic signed [wmco_pkg::OFS_W-1:0] dev_calc;
    logic [wmco_pkg::TS_W-1:0]         noise_a;
    logic [wmco_pkg::TS_W-1:0]         noise_b;
    stim_t                             s;
    int                                pick;

    // Extremes, absent timestamps, alternating bit patterns.
    pending_items.push_back('{'0, '0, 1'b0});
    pending_items.push_back('{'0, TS_MAX, 1'b0});
    pending_items.push_back('{TS_MAX, TS_MAX, 1'b0});
    pending_items.push_back('{63'd1, '0, 1'b0});
    pending_items.push_back('{'0, 63'd12345, 1'b0});
    pending_items.push_back('{TS_MAX, '0, 1'b0});
    pending_items.push_back('{63'd1, TS_MAX, 1'b0});
    pending_items.push_back('{{1'b0, {31{2'b10}}}, {1'b0, {31{2'b01}}}, 1'b0});
    pending_items.push_back('{63'h2aaa_aaaa_aaaa_aaaa, 63'h5555_5555_5555_5555, 1'b0});
    pending_items.push_back('{TS_MAX, 63'd1, 1'b0});
    pending_items.push_back('{'0, 63'd1, 1'b0});

    arr_clock = (64'sd1 <<< 52) + $urandom;
    skew      = ($signed({32'd0, $urandom}) <<< 8) - (64'sd1 <<< 39);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      arr_clock += $urandom_range(1, 50_000_000);
      if ($urandom_range(0, 199) == 0) skew = ($signed({32'd0, $urandom}) <<< 8) - (64'sd1 <<< 39);
      noise_a = wmco_pkg::TS_W'({$urandom, $urandom} >> $urandom_range(0, 62));
      noise_b = wmco_pkg::TS_W'({$urandom, $urandom} >> $urandom_range(0, 62));
      pick = $urandom_range(0, 99);
      if (k >= 150 && k < 250 && pick < 15) begin
        s.device_ns  = noise_a;
        s.arrival_ns = noise_b;
      end else if (pick < 10) begin
        s.device_ns  = '0;
        s.arrival_ns = (pick < 3) ? noise_b : arr_clock[wmco_pkg::TS_W-1:0];
      end else begin
        dev_calc     = arr_clock - skew - $urandom_range(0, 2_000_000);
        s.device_ns  = dev_calc[wmco_pkg::TS_W-1:0];
        s.arrival_ns = arr_clock[wmco_pkg::TS_W-1:0];
      end
      s.drain_first = (k == 0) || (k == 700);
      pending_items.push_back(s);
    end

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_items.size() == 0 && !offering);
    wait (host_time_predictions.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("%0d items: %0d with device time, %0d without; %0d results checked",
             n_sent, n_sent - n_absent, n_absent, n_results);
    $display("window wrapped with %0d overwrites; output held off %0d cycles once",
             n_overwrites, HOLD_CYCLES);
    if (n_failures == 0 && host_time_predictions.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+design
design/wmco_pkg.sv
design/wmco_datapath.sv
design/wmco_ctrl.sv
design/windowed_min_clock_offset_unit.sv
design/wmco_checker.sv
tb/windowed_min_clock_offset_unit_test.sv
